### rtl/core/fbcm_pkg.sv
// Shared types, codes and the sequencer control store of the block chain manager.
package fbcm_pkg;

    localparam int IDX_W      = 6;
    localparam int BYTES_W    = 24;
    localparam int BSZ_W      = 13;
    localparam int BIN_W      = 7;
    localparam int CNT_W      = 7;
    localparam int DCNT_W     = 5;
    localparam int PC_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(BYTES_W);

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_WALK  = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SPACE  = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_BAD_START = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = CFG_IDX_W'(1);

    localparam logic [BSZ_W-1:0] BSZ_RESET = BSZ_W'(512);
    localparam logic [BIN_W-1:0] BIN_RESET = BIN_W'(64);

    typedef struct packed {
        logic [1:0]         kind;
        logic [BYTES_W-1:0] byte_size;
        logic [IDX_W-1:0]   start_block;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] block_index;
        logic             last;
        logic [2:0]       status;
    } t_res;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg;

    // Datapath actions, one per control word.
    typedef enum logic [3:0] {
        A_NOP,
        A_LATCH,
        A_DIV_INIT,
        A_DIV_STEP,
        A_NEED,
        A_COUNT,
        A_CLAIM_INIT,
        A_CLAIM,
        A_WALK_INIT,
        A_WALK,
        A_EMIT_EMPTY,
        A_EMIT_NOSPACE
    } t_act;

    // Jump conditions; a taken jump loads the target, otherwise the step counter advances; a stall holds it.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOREQ,
        C_IS_WALK,
        C_NOT_ALLOC,
        C_EMPTY,
        C_DIV_MORE,
        C_SCAN_MORE,
        C_NO_SPACE,
        C_CLAIM_MORE,
        C_WALK_MORE
    } t_cond;

    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_pc   target;
    } t_uword;

    localparam t_pc PC_IDLE     = 4'd0;
    localparam t_pc PC_DISP     = 4'd1;
    localparam t_pc PC_KCHK     = 4'd2;
    localparam t_pc PC_DIVINIT  = 4'd3;
    localparam t_pc PC_DIV      = 4'd4;
    localparam t_pc PC_NEED     = 4'd5;
    localparam t_pc PC_COUNT    = 4'd6;
    localparam t_pc PC_CHECK    = 4'd7;
    localparam t_pc PC_CLAIM    = 4'd8;
    localparam t_pc PC_ADONE    = 4'd9;
    localparam t_pc PC_WALK     = 4'd10;
    localparam t_pc PC_STEP     = 4'd11;
    localparam t_pc PC_WDONE    = 4'd12;
    localparam t_pc PC_EMPTY    = 4'd13;
    localparam t_pc PC_NOSPACE  = 4'd14;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:    w = '{A_LATCH,        C_NOREQ,      PC_IDLE};
            PC_DISP:    w = '{A_NOP,          C_IS_WALK,    PC_WALK};
            PC_KCHK:    w = '{A_NOP,          C_NOT_ALLOC,  PC_IDLE};
            PC_DIVINIT: w = '{A_DIV_INIT,     C_EMPTY,      PC_EMPTY};
            PC_DIV:     w = '{A_DIV_STEP,     C_DIV_MORE,   PC_DIV};
            PC_NEED:    w = '{A_NEED,         C_NEVER,      PC_IDLE};
            PC_COUNT:   w = '{A_COUNT,        C_SCAN_MORE,  PC_COUNT};
            PC_CHECK:   w = '{A_CLAIM_INIT,   C_NO_SPACE,   PC_NOSPACE};
            PC_CLAIM:   w = '{A_CLAIM,        C_CLAIM_MORE, PC_CLAIM};
            PC_ADONE:   w = '{A_NOP,          C_ALWAYS,     PC_IDLE};
            PC_WALK:    w = '{A_WALK_INIT,    C_NEVER,      PC_IDLE};
            PC_STEP:    w = '{A_WALK,         C_WALK_MORE,  PC_STEP};
            PC_WDONE:   w = '{A_NOP,          C_ALWAYS,     PC_IDLE};
            PC_EMPTY:   w = '{A_EMIT_EMPTY,   C_ALWAYS,     PC_IDLE};
            PC_NOSPACE: w = '{A_EMIT_NOSPACE, C_ALWAYS,     PC_IDLE};
            default:    w = '{A_NOP,          C_ALWAYS,     PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

### rtl/core/fbcm_stream_if.sv
// Valid/ready channel carrying one payload of a given type per request.
interface fbcm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/fat_block_chain_manager.sv
// Block chain table manager: allocate, walk and free chains, driven by a microcoded sequencer.
// One request at a time; an unknown kind returns to idle with no results. The 24-step divider
// runs before the count loop, and the count, claim and walk loops visit one table entry per
// cycle unless a held result stalls the sequencer. Reset is synchronous: every block free,
// block_size 512, blocks_in_use 64, no clearing pass.
module fat_block_chain_manager #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fbcm_stream_if.sink   i_req,
    fbcm_stream_if.source o_res,
    fbcm_stream_if.sink   i_cfg
);
    import fbcm_pkg::*;

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // Configuration registers.
    logic [BSZ_W-1:0]   r_block_size, n_block_size;
    logic [BIN_W-1:0]   r_blocks_in_use, n_blocks_in_use;

    // Sequencer step counter and the current control word.
    t_pc                r_pc, n_pc;
    t_uword             uw;
    logic               jump;
    logic               stall;

    // Latched request.
    logic [1:0]         r_kind, n_kind;
    logic [BYTES_W-1:0] r_bytes, n_bytes;
    logic [IDX_W-1:0]   r_start, n_start;

    // Restoring divider: one quotient bit per step.
    logic [BSZ_W-1:0]   r_bsz, n_bsz;
    logic [BSZ_W-1:0]   r_rem, n_rem;
    logic [BYTES_W-1:0] r_quo, n_quo;
    logic [DCNT_W-1:0]  r_dcnt, n_dcnt;
    logic [BSZ_W:0]     trial;
    logic               trial_ge;

    // Allocation scan.
    logic [BYTES_W-1:0] r_need, n_need;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [IDX_W-1:0]   r_prev, n_prev;
    logic [CNT_W-1:0]   lim;
    logic [AW-1:0]      idx_lo;
    logic               slot_free;
    logic               claim_last;

    // Chain walk.
    logic [IDX_W-1:0]   r_cur, n_cur;
    logic [AW-1:0]      r_steps, n_steps;
    logic [AW-1:0]      cur_lo;
    logic               walk_bad, walk_end, walk_long, walk_done;

    // Per-block marks, cleared by reset.
    logic [NUM_BLOCKS-1:0] r_used, n_used;
    logic [NUM_BLOCKS-1:0] r_end, n_end;

    // Link memory: one write port for the claim loop, registered read for the walk.
    logic [IDX_W-1:0]   mem [NUM_BLOCKS];
    logic               mem_we;
    logic [IDX_W-1:0]   r_nb_q;

    // Result register parts the sequencer from the result channel.
    logic               r_out_valid, n_out_valid;
    t_res               r_out, n_out;
    logic               out_free;
    logic               emit;

    assign uw       = ucode(r_pc);
    assign out_free = !r_out_valid || o_res.ready;

    assign i_req.ready = (r_pc == PC_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Blocks open to allocation are clamped to the table depth.
    assign lim = (r_blocks_in_use > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : r_blocks_in_use;

    assign idx_lo     = r_idx[AW-1:0];
    assign slot_free  = !r_used[idx_lo];
    assign claim_last = slot_free && ((BYTES_W'(r_k) + BYTES_W'(1)) == r_need);

    // A start or link outside the table, or onto a free block, ends the walk as a bad start.
    assign cur_lo    = r_cur[AW-1:0];
    assign walk_bad  = ({1'b0, r_cur} >= CNT_W'(NUM_BLOCKS)) || !r_used[cur_lo];
    assign walk_end  = r_end[cur_lo];
    assign walk_long = (r_steps == AW'(NUM_BLOCKS - 1));
    assign walk_done = walk_bad || walk_end || walk_long;

    assign trial    = {r_rem, r_quo[BYTES_W-1]};
    assign trial_ge = (trial >= {1'b0, r_bsz});

    always_comb begin
        unique case (uw.act)
            A_CLAIM:        emit = slot_free;
            A_WALK:         emit = 1'b1;
            A_EMIT_EMPTY:   emit = 1'b1;
            A_EMIT_NOSPACE: emit = 1'b1;
            default:        emit = 1'b0;
        endcase
    end

    // The only stall: a step that produces a result while the result register is still held.
    assign stall = emit && !out_free;

    always_comb begin
        unique case (uw.cond)
            C_NEVER:      jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_NOREQ:      jump = !i_req.valid;
            C_IS_WALK:    jump = (r_kind == KIND_WALK) || (r_kind == KIND_FREE);
            C_NOT_ALLOC:  jump = (r_kind != KIND_ALLOC);
            C_EMPTY:      jump = (r_bytes == '0);
            C_DIV_MORE:   jump = (r_dcnt != DCNT_W'(1));
            C_SCAN_MORE:  jump = ((r_idx + CNT_W'(1)) < lim);
            C_NO_SPACE:   jump = (r_need > BYTES_W'(r_cnt));
            C_CLAIM_MORE: jump = !claim_last;
            C_WALK_MORE:  jump = !walk_done;
            default:      jump = 1'b0;
        endcase
    end

    always_comb begin
        n_block_size    = r_block_size;
        n_blocks_in_use = r_blocks_in_use;
        n_kind          = r_kind;
        n_bytes         = r_bytes;
        n_start         = r_start;
        n_bsz           = r_bsz;
        n_rem           = r_rem;
        n_quo           = r_quo;
        n_dcnt          = r_dcnt;
        n_need          = r_need;
        n_idx           = r_idx;
        n_cnt           = r_cnt;
        n_k             = r_k;
        n_prev          = r_prev;
        n_cur           = r_cur;
        n_steps         = r_steps;
        n_used          = r_used;
        n_end           = r_end;
        n_out           = r_out;
        n_out_valid     = o_res.ready ? 1'b0 : r_out_valid;
        mem_we          = 1'b0;

        if (i_cfg.valid) begin
            unique case (i_cfg.data.reg_index)
                REG_BLOCK_SIZE:    n_block_size    = i_cfg.data.wdata;
                REG_BLOCKS_IN_USE: n_blocks_in_use = i_cfg.data.wdata[BIN_W-1:0];
                default:           ;
            endcase
        end

        unique case (uw.act)
            A_NOP: ;
            A_LATCH: begin
                if (i_req.valid) begin
                    n_kind  = i_req.data.kind;
                    n_bytes = i_req.data.byte_size;
                    n_start = i_req.data.start_block;
                end
            end
            A_DIV_INIT: begin
                // A block size of zero counts as one byte per block.
                n_bsz  = (r_block_size == '0) ? BSZ_W'(1) : r_block_size;
                n_rem  = '0;
                n_quo  = r_bytes;
                n_dcnt = DIV_STEPS;
            end
            A_DIV_STEP: begin
                n_rem  = trial_ge ? BSZ_W'(trial - {1'b0, r_bsz}) : trial[BSZ_W-1:0];
                n_quo  = {r_quo[BYTES_W-2:0], trial_ge};
                n_dcnt = r_dcnt - DCNT_W'(1);
            end
            A_NEED: begin
                // Round up; cannot overflow since a remainder implies a block size of two or more.
                n_need = r_quo + BYTES_W'(r_rem != '0);
                n_idx  = '0;
                n_cnt  = '0;
            end
            A_COUNT: begin
                if (r_idx < lim) begin
                    if (slot_free) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            A_CLAIM_INIT: begin
                n_idx = '0;
                n_k   = '0;
            end
            A_CLAIM: begin
                if (!stall) begin
                    if (slot_free) begin
                        mem_we           = (r_k != '0);
                        n_used[idx_lo]   = 1'b1;
                        n_end[idx_lo]    = claim_last;
                        n_prev           = r_idx[IDX_W-1:0];
                        n_k              = r_k + CNT_W'(1);
                        n_out_valid      = 1'b1;
                        n_out            = '{block_index: r_idx[IDX_W-1:0],
                                             last: claim_last, status: ST_OK};
                    end
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            A_WALK_INIT: begin
                n_cur   = r_start;
                n_steps = '0;
            end
            A_WALK: begin
                if (!stall) begin
                    n_out_valid       = 1'b1;
                    n_out.block_index = r_cur;
                    n_out.last        = walk_done;
                    if (walk_bad) begin
                        n_out.status = ST_BAD_START;
                    end else if (walk_end) begin
                        n_out.status = ST_OK;
                    end else if (walk_long) begin
                        n_out.status = ST_TOO_LONG;
                    end else begin
                        n_out.status = ST_OK;
                    end
                    if (!walk_bad && (r_kind == KIND_FREE)) begin
                        n_used[cur_lo] = 1'b0;
                        n_end[cur_lo]  = 1'b0;
                    end
                    if (!walk_done) begin
                        n_cur   = r_nb_q;
                        n_steps = r_steps + AW'(1);
                    end
                end
            end
            A_EMIT_EMPTY: begin
                if (!stall) begin
                    n_out_valid = 1'b1;
                    n_out       = '{block_index: '0, last: 1'b1, status: ST_EMPTY};
                end
            end
            A_EMIT_NOSPACE: begin
                if (!stall) begin
                    n_out_valid = 1'b1;
                    n_out       = '{block_index: '0, last: 1'b1, status: ST_NO_SPACE};
                end
            end
            default: ;
        endcase

        if (stall) begin
            n_pc = r_pc;
        end else if (jump) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    // The read address follows the next walk position, so the link of the block being
    // visited is ready in the cycle that visits it.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_prev[AW-1:0]] <= r_idx[IDX_W-1:0];
        end
        r_nb_q <= mem[n_cur[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc            <= PC_IDLE;
            r_block_size    <= BSZ_RESET;
            r_blocks_in_use <= BIN_RESET;
            r_used          <= '0;
            r_end           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_pc            <= n_pc;
            r_block_size    <= n_block_size;
            r_blocks_in_use <= n_blocks_in_use;
            r_used          <= n_used;
            r_end           <= n_end;
            r_out_valid     <= n_out_valid;
        end
        r_kind  <= n_kind;
        r_bytes <= n_bytes;
        r_start <= n_start;
        r_bsz   <= n_bsz;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dcnt  <= n_dcnt;
        r_need  <= n_need;
        r_idx   <= n_idx;
        r_cnt   <= n_cnt;
        r_k     <= n_k;
        r_prev  <= n_prev;
        r_cur   <= n_cur;
        r_steps <= n_steps;
        r_out   <= n_out;
    end

    // Once the final result of a request is loaded, the sequencer leaves its emitting steps.
    a_last_ends_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !stall && n_out.last) |=>
            (r_pc == PC_ADONE || r_pc == PC_WDONE || r_pc == PC_IDLE))
        else $error("sequencer kept emitting after the final result");

    // The claim loop never claims more blocks than the request needs.
    a_claim_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_CLAIM) |-> (BYTES_W'(r_k) < r_need))
        else $error("claim count reached the block need");

    // The free count from the scan never exceeds the blocks open to allocation.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_CHECK) |-> (r_cnt <= lim))
        else $error("free count above allocation limit");

endmodule
